@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define ASSERT_IMPL(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ant, cons)
`define ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

@@ rtl/fmp_pkg.sv @@
// Types and constants of the framed message parser.
package fmp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned EVENT_W   = 3;
	localparam int unsigned CAUSE_W   = 3;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL = 8'd1;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_TAIL    = 3'd3,
		PH_CKSUM   = 3'd4,
		PH_CR      = 3'd5,
		PH_LF      = 3'd6
	} phase_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE   = 3'd0,
		EV_ID     = 3'd1,
		EV_DATA   = 3'd2,
		EV_ACCEPT = 3'd3,
		EV_REJECT = 3'd4
	} event_t;

	typedef enum logic [CAUSE_W-1:0] {
		ERR_NONE    = 3'd0,
		ERR_SHORT   = 3'd1,
		ERR_TAIL_IN = 3'd2,
		ERR_NO_TAIL = 3'd3,
		ERR_SUM     = 3'd4,
		ERR_LINE    = 3'd5
	} cause_t;

	// Parser context carried from byte to byte
	typedef struct packed {
		phase_t            phase;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] payload_count;
		logic [BYTE_W-1:0] running_sum;
		logic [BYTE_W-1:0] held_id;
	} ctx_t;

	// One result transaction
	typedef struct packed {
		event_t            event_res;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] frame_id;
		cause_t            error_cause;
	} result_t;

endpackage

@@ rtl/fmp_ifs.sv @@
// Handshake channels of the framed message parser: input byte, result, config write.
interface fmp_in_if;
	logic                          valid;
	logic                          ready;
	logic [fmp_pkg::BYTE_W-1:0]    rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fmp_out_if;
	logic                          valid;
	logic                          ready;
	logic [fmp_pkg::EVENT_W-1:0]   event_res;
	logic [fmp_pkg::BYTE_W-1:0]    data_byte;
	logic [fmp_pkg::BYTE_W-1:0]    frame_id;
	logic [fmp_pkg::CAUSE_W-1:0]   error_cause;
	modport source (output valid, output event_res, output data_byte, output frame_id,
		output error_cause, input ready);
	modport sink   (input valid, input event_res, input data_byte, input frame_id,
		input error_cause, output ready);
endinterface

interface fmp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fmp_pkg::CFG_IDX_W-1:0] index;
	logic [fmp_pkg::BYTE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/fmp_step.sv @@
// One parse step: next context and result for one received byte.
module fmp_step (
	input  fmp_pkg::ctx_t                 ctx,
	input  logic [fmp_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [fmp_pkg::BYTE_W-1:0]    head_byte,
	input  logic [fmp_pkg::BYTE_W-1:0]    tail_byte,
	output fmp_pkg::ctx_t                 ctx_nxt,
	output fmp_pkg::result_t              result
);

	// BSD checksum step: rotate right by one, then add
	function automatic logic [fmp_pkg::BYTE_W-1:0] sum_add(
		input logic [fmp_pkg::BYTE_W-1:0] s,
		input logic [fmp_pkg::BYTE_W-1:0] b
	);
		return {s[0], s[fmp_pkg::BYTE_W-1:1]} + b;
	endfunction

	logic                         first;
	logic [fmp_pkg::BYTE_W-1:0]   count_inc;

	assign first     = (ctx.payload_count == '0);
	assign count_inc = ctx.payload_count + 8'd1;

	always_comb begin
		ctx_nxt = ctx;
		result  = '{event_res: fmp_pkg::EV_NONE, data_byte: '0, frame_id: '0,
			error_cause: fmp_pkg::ERR_NONE};
		unique case (ctx.phase)
			fmp_pkg::PH_HUNT: begin
				if (rx_byte == head_byte) begin
					ctx_nxt.phase   = fmp_pkg::PH_LEN;
					ctx_nxt.held_id = '0;
				end
			end
			fmp_pkg::PH_LEN: begin
				ctx_nxt.frame_length  = rx_byte;
				ctx_nxt.payload_count = '0;
				ctx_nxt.running_sum   = '0;
				ctx_nxt.held_id       = '0;
				if (rx_byte < fmp_pkg::MIN_LEN) begin
					ctx_nxt.phase      = fmp_pkg::PH_HUNT;
					result.event_res   = fmp_pkg::EV_REJECT;
					result.error_cause = fmp_pkg::ERR_SHORT;
				end else begin
					ctx_nxt.phase = fmp_pkg::PH_PAYLOAD;
				end
			end
			fmp_pkg::PH_PAYLOAD: begin
				if (first) begin
					ctx_nxt.held_id = rx_byte;
				end
				if (rx_byte == tail_byte) begin
					// the id byte itself may be the offender; it still names the frame
					ctx_nxt.phase      = fmp_pkg::PH_HUNT;
					result.event_res   = fmp_pkg::EV_REJECT;
					result.frame_id    = first ? rx_byte : ctx.held_id;
					result.error_cause = fmp_pkg::ERR_TAIL_IN;
				end else begin
					ctx_nxt.running_sum   = sum_add(ctx.running_sum, rx_byte);
					ctx_nxt.payload_count = count_inc;
					if (count_inc >= ctx.frame_length) begin
						ctx_nxt.phase = fmp_pkg::PH_TAIL;
					end
					result.event_res = first ? fmp_pkg::EV_ID : fmp_pkg::EV_DATA;
					result.data_byte = rx_byte;
				end
			end
			fmp_pkg::PH_TAIL: begin
				if (rx_byte == tail_byte) begin
					ctx_nxt.phase = fmp_pkg::PH_CKSUM;
				end else begin
					ctx_nxt.phase      = fmp_pkg::PH_HUNT;
					result.event_res   = fmp_pkg::EV_REJECT;
					result.frame_id    = ctx.held_id;
					result.error_cause = fmp_pkg::ERR_NO_TAIL;
				end
			end
			fmp_pkg::PH_CKSUM: begin
				if (rx_byte == ctx.running_sum) begin
					ctx_nxt.phase = fmp_pkg::PH_CR;
				end else begin
					ctx_nxt.phase      = fmp_pkg::PH_HUNT;
					result.event_res   = fmp_pkg::EV_REJECT;
					result.frame_id    = ctx.held_id;
					result.error_cause = fmp_pkg::ERR_SUM;
				end
			end
			fmp_pkg::PH_CR: begin
				if (rx_byte == fmp_pkg::CHAR_CR) begin
					ctx_nxt.phase = fmp_pkg::PH_LF;
				end else begin
					ctx_nxt.phase      = fmp_pkg::PH_HUNT;
					result.event_res   = fmp_pkg::EV_REJECT;
					result.frame_id    = ctx.held_id;
					result.error_cause = fmp_pkg::ERR_LINE;
				end
			end
			fmp_pkg::PH_LF: begin
				ctx_nxt.phase   = fmp_pkg::PH_HUNT;
				result.frame_id = ctx.held_id;
				if (rx_byte == fmp_pkg::CHAR_LF) begin
					result.event_res = fmp_pkg::EV_ACCEPT;
				end else begin
					result.event_res   = fmp_pkg::EV_REJECT;
					result.error_cause = fmp_pkg::ERR_LINE;
				end
			end
			default: begin
				ctx_nxt.phase = fmp_pkg::PH_HUNT;
			end
		endcase
	end

endmodule

@@ rtl/framed_message_parser_core.sv @@
// Top level of the framed message parser: context and result registers around one parse step.
//
//  channel | dir | payload                                       | transaction
//  --------+-----+-----------------------------------------------+----------------------
//  rx      | in  | rx_byte                                       | valid & ready
//  res     | out | event_res, data_byte, frame_id, error_cause   | valid & ready
//  cfg     | in  | index, data (0 head byte, 1 tail byte)        | valid & ready
//
// Every rx transaction yields exactly one result, offered on res in the next cycle.
// Throughput is one byte per cycle while res does not stall; the single result register is the only stage,
// and rx.ready is high whenever that register is empty or being drained.
// A stalled res holds its transaction and back-pressures rx; nothing is dropped.
// arst_n clears the parse context, the config registers and the result valid.
// cfg is always ready; writes take effect on the next byte.
`include "assert_macros.svh"

module framed_message_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	fmp_in_if.sink      rx,
	fmp_out_if.source   res,
	fmp_cfg_if.sink     cfg
);

	fmp_pkg::ctx_t                 ctx_q;
	fmp_pkg::ctx_t                 ctx_nxt;
	fmp_pkg::result_t              step_res;
	fmp_pkg::result_t              res_q;
	logic                          res_valid_q;
	logic [fmp_pkg::BYTE_W-1:0]    head_q;
	logic [fmp_pkg::BYTE_W-1:0]    tail_q;
	logic                          rx_fire;
	logic                          res_verdict;
	logic                          lf_fire;

	// Take a new byte whenever the result register is free or frees up this cycle
	assign rx.ready  = !res_valid_q || res.ready;
	assign rx_fire   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	// Config registers; indexes beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fmp_pkg::REG_HEAD: head_q <= cfg.data;
				fmp_pkg::REG_TAIL: tail_q <= cfg.data;
				default: ;
			endcase
		end
	end

	fmp_step u_step (
		.ctx       (ctx_q),
		.rx_byte   (rx.rx_byte),
		.head_byte (head_q),
		.tail_byte (tail_q),
		.ctx_nxt   (ctx_nxt),
		.result    (step_res)
	);

	// Parse context advances once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{phase: fmp_pkg::PH_HUNT, frame_length: '0, payload_count: '0,
				running_sum: '0, held_id: '0};
		end else if (rx_fire) begin
			ctx_q <= ctx_nxt;
		end
	end

	// Result register: valid is control, the payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			res_q <= step_res;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.event_res   = res_q.event_res;
	assign res.data_byte   = res_q.data_byte;
	assign res.frame_id    = res_q.frame_id;
	assign res.error_cause = res_q.error_cause;

	// helpers for the checks below
	assign res_verdict = res.valid && (res.event_res == fmp_pkg::EV_ACCEPT ||
		res.event_res == fmp_pkg::EV_REJECT);
	assign lf_fire     = rx_fire && ctx_q.phase == fmp_pkg::PH_LF &&
		rx.rx_byte == fmp_pkg::CHAR_LF;

	// Every accepted byte shows up as a result in the next cycle
	`ASSERT_NEXT(a_rx_gives_res, rx_fire, res.valid)
	// A verdict on the output means the parser went back to hunting
	`ASSERT_IMPL(a_verdict_hunts, res_verdict, ctx_q.phase == fmp_pkg::PH_HUNT)
	// A good LF after CR yields an accept
	`ASSERT_NEXT(a_lf_accepts, lf_fire, res.event_res == fmp_pkg::EV_ACCEPT)

endmodule

@@ tb/sv/fmp_frame_checker.sv @@
// Frame checker: follows the rx, res and cfg channels, predicts each result and compares it.
`timescale 1ns / 1ps

module fmp_frame_checker (
	input  logic clk,
	input  logic arst_n,
	fmp_in_if    rx,
	fmp_out_if   res,
	fmp_cfg_if   cfg,
	output int   mismatch_cnt,
	output int   pending_cnt
);

	// shadow copy of the config and of the parse context
	logic [fmp_pkg::BYTE_W-1:0] head_val;
	logic [fmp_pkg::BYTE_W-1:0] tail_val;
	fmp_pkg::phase_t            parse_ph;
	logic [fmp_pkg::BYTE_W-1:0] frame_len;
	logic [fmp_pkg::BYTE_W-1:0] bytes_in;
	logic [fmp_pkg::BYTE_W-1:0] sum_acc;
	logic [fmp_pkg::BYTE_W-1:0] cur_id;

	fmp_pkg::result_t due_results[$];
	fmp_pkg::result_t want;
	int               res_idx;

	function automatic fmp_pkg::result_t reject_with(input fmp_pkg::cause_t why);
		fmp_pkg::result_t r;
		r             = '0;
		r.event_res   = fmp_pkg::EV_REJECT;
		r.frame_id    = cur_id;
		r.error_cause = why;
		parse_ph      = fmp_pkg::PH_HUNT;
		return r;
	endfunction

	// advance the parse context by one byte, return the result it causes
	function automatic fmp_pkg::result_t parsed_result(input logic [fmp_pkg::BYTE_W-1:0] b);
		fmp_pkg::result_t r;
		logic             first;
		r             = '0;
		r.event_res   = fmp_pkg::EV_NONE;
		r.error_cause = fmp_pkg::ERR_NONE;
		case (parse_ph)
			fmp_pkg::PH_HUNT: begin
				if (b == head_val) begin
					parse_ph = fmp_pkg::PH_LEN;
					cur_id   = '0;
				end
			end
			fmp_pkg::PH_LEN: begin
				frame_len = b;
				bytes_in  = '0;
				sum_acc   = '0;
				cur_id    = '0;
				if (b < fmp_pkg::MIN_LEN)
					r = reject_with(fmp_pkg::ERR_SHORT);
				else
					parse_ph = fmp_pkg::PH_PAYLOAD;
			end
			fmp_pkg::PH_PAYLOAD: begin
				first = (bytes_in == '0);
				if (first)
					cur_id = b;
				if (b == tail_val) begin
					r = reject_with(fmp_pkg::ERR_TAIL_IN);
				end else begin
					sum_acc  = {sum_acc[0], sum_acc[fmp_pkg::BYTE_W-1:1]} + b;
					bytes_in = bytes_in + 1'b1;
					if (bytes_in >= frame_len)
						parse_ph = fmp_pkg::PH_TAIL;
					r.event_res = first ? fmp_pkg::EV_ID : fmp_pkg::EV_DATA;
					r.data_byte = b;
				end
			end
			fmp_pkg::PH_TAIL: begin
				if (b == tail_val)
					parse_ph = fmp_pkg::PH_CKSUM;
				else
					r = reject_with(fmp_pkg::ERR_NO_TAIL);
			end
			fmp_pkg::PH_CKSUM: begin
				if (b == sum_acc)
					parse_ph = fmp_pkg::PH_CR;
				else
					r = reject_with(fmp_pkg::ERR_SUM);
			end
			fmp_pkg::PH_CR: begin
				if (b == fmp_pkg::CHAR_CR)
					parse_ph = fmp_pkg::PH_LF;
				else
					r = reject_with(fmp_pkg::ERR_LINE);
			end
			fmp_pkg::PH_LF: begin
				if (b == fmp_pkg::CHAR_LF) begin
					r.event_res = fmp_pkg::EV_ACCEPT;
					r.frame_id  = cur_id;
					parse_ph    = fmp_pkg::PH_HUNT;
				end else begin
					r = reject_with(fmp_pkg::ERR_LINE);
				end
			end
			default: parse_ph = fmp_pkg::PH_HUNT;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			head_val     = '0;
			tail_val     = '0;
			parse_ph     = fmp_pkg::PH_HUNT;
			frame_len    = '0;
			bytes_in     = '0;
			sum_acc      = '0;
			cur_id       = '0;
			mismatch_cnt = 0;
			pending_cnt  = 0;
			res_idx      = 0;
		end else begin
			// result first: it belongs to a byte accepted on an earlier edge
			if (res.valid && res.ready) begin
				if (due_results.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("result %0d: unexpected, ev %0d data %02h id %02h cause %0d",
							res_idx, res.event_res, res.data_byte, res.frame_id,
							res.error_cause);
					mismatch_cnt++;
				end else begin
					want = due_results.pop_front();
					if (res.event_res !== want.event_res || res.data_byte !== want.data_byte ||
					    res.frame_id !== want.frame_id ||
					    res.error_cause !== want.error_cause) begin
						if (mismatch_cnt < 10)
							$display({"result %0d: expected ev %0d data %02h id %02h cause %0d,",
								" got ev %0d data %02h id %02h cause %0d"}, res_idx,
								want.event_res, want.data_byte, want.frame_id,
								want.error_cause, res.event_res, res.data_byte,
								res.frame_id, res.error_cause);
						mismatch_cnt++;
					end
				end
				res_idx++;
			end
			if (rx.valid && rx.ready)
				due_results.push_back(parsed_result(rx.rx_byte));
			// a write affects the bytes after it
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					fmp_pkg::REG_HEAD: head_val = cfg.data;
					fmp_pkg::REG_TAIL: tail_val = cfg.data;
					default: ;
				endcase
			end
			pending_cnt = due_results.size();
		end
	end

endmodule

@@ tb/sv/framed_message_parser_core_test.sv @@
// Top of the parser test: clock, reset, byte and config stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module framed_message_parser_core_test;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 6;
	localparam int PER_PHASE   = 200;   // frame bytes per random phase
	localparam int HOLD_CYCLES = 400;   // long res stall that backs up rx

	// indexes past the register file, must be ignored
	localparam logic [fmp_pkg::CFG_IDX_W-1:0] REG_SPARE   = 8'd2;
	localparam logic [fmp_pkg::CFG_IDX_W-1:0] REG_TOP_IDX = 8'hFF;

	// how a generated frame is broken, if at all
	typedef enum int {
		INJ_NONE,
		INJ_SHORT,
		INJ_TAIL_IN,
		INJ_NO_TAIL,
		INJ_SUM,
		INJ_CR,
		INJ_LF
	} inject_t;

	// res.ready behavior within one segment
	typedef enum int {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_PATTERN,
		RDY_SPARSE
	} rdy_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fmp_in_if  rx_ch ();
	fmp_out_if res_ch ();
	fmp_cfg_if cfg_ch ();

	int fail_cnt;
	int pending_cnt;
	int cycle_cnt = 0;

	// sender bookkeeping
	int   sent_total = 0;
	int   burst_left = 0;
	// current register values, used to build frames
	logic [fmp_pkg::BYTE_W-1:0] head_cur = '0;
	logic [fmp_pkg::BYTE_W-1:0] tail_cur = '0;
	// request for one long res stall
	logic hold_now  = 1'b0;
	int   hold_left = 0;

	framed_message_parser_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	fmp_frame_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_ch),
		.res          (res_ch),
		.cfg          (cfg_ch),
		.mismatch_cnt (fail_cnt),
		.pending_cnt  (pending_cnt)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// BSD rotate-right-and-add, to build frames with a valid checksum
	function automatic logic [fmp_pkg::BYTE_W-1:0] bsd_step(
		input logic [fmp_pkg::BYTE_W-1:0] s,
		input logic [fmp_pkg::BYTE_W-1:0] b);
		return {s[0], s[fmp_pkg::BYTE_W-1:1]} + b;
	endfunction

	// Offer one byte from a falling edge until its transaction completes. Returns at a
	// falling edge. Between bursts valid drops for a random gap; inside a burst it stays
	// high, so valid is never lowered and raised in the same step.
	task automatic send_byte(input logic [fmp_pkg::BYTE_W-1:0] b);
		int gap;
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent_total++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
	endtask

	// One config transaction; valid is left high so writes can go back to back.
	task automatic write_reg(input logic [fmp_pkg::CFG_IDX_W-1:0] idx,
		input logic [fmp_pkg::BYTE_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [fmp_pkg::BYTE_W-1:0] h,
		input logic [fmp_pkg::BYTE_W-1:0] t);
		write_reg(fmp_pkg::REG_HEAD, h);
		write_reg(fmp_pkg::REG_TAIL, t);
		cfg_ch.valid <= 1'b0;
		head_cur = h;
		tail_cur = t;
	endtask

	// Stop offering bytes and wait until every predicted result has come out. Every byte
	// gives a result, so once the queue is empty the block holds no work.
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Send head, length, body, tail, checksum, CR, LF with the chosen break. The frame is
	// cut off right after the byte that rejects it; the rest would only be hunted over.
	task automatic send_frame(input logic [fmp_pkg::BYTE_W-1:0] len_byte,
		input logic [fmp_pkg::BYTE_W-1:0] body[$], input inject_t inj);
		logic [fmp_pkg::BYTE_W-1:0] ck;
		logic [fmp_pkg::BYTE_W-1:0] b;
		int                         i;
		ck = '0;
		send_byte(head_cur);
		send_byte(len_byte);
		if (len_byte < fmp_pkg::MIN_LEN)
			return;
		for (i = 0; i < body.size(); i++) begin
			send_byte(body[i]);
			if (body[i] == tail_cur)
				return;
			ck = bsd_step(ck, body[i]);
		end
		if (inj == INJ_NO_TAIL) begin
			send_byte(tail_cur ^ 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(tail_cur);
		if (inj == INJ_SUM) begin
			send_byte(ck + 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(ck);
		b = (inj == INJ_CR) ? 8'($urandom_range(0, 255)) : fmp_pkg::CHAR_CR;
		if (inj == INJ_CR && b == fmp_pkg::CHAR_CR)
			b = b ^ 8'h01;
		send_byte(b);
		if (inj == INJ_CR)
			return;
		b = (inj == INJ_LF) ? 8'($urandom_range(0, 255)) : fmp_pkg::CHAR_LF;
		if (inj == INJ_LF && b == fmp_pkg::CHAR_LF)
			b = b ^ 8'h01;
		send_byte(b);
	endtask

	// Receiver: res.ready changes on falling edges, segment by segment in a random mode.
	// A hold request overrides everything while the hold counter runs, so the result register fills
	// and rx.ready must drop while the sender keeps offering.
	initial begin
		rdy_mode_t                  mode;
		int                         seg_len;
		int                         k;
		logic [fmp_pkg::BYTE_W-1:0] pat;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode    = rdy_mode_t'($urandom_range(0, 3));
			seg_len = $urandom_range(10, 150);
			pat     = 8'($urandom) | 8'h01;
			for (k = 0; k < seg_len; k++) begin
				@(negedge clk);
				if (hold_now) begin
					hold_now  = 1'b0;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					res_ch.ready <= 1'b0;
				end else begin
					case (mode)
						RDY_ALWAYS:  res_ch.ready <= 1'b1;
						RDY_RANDOM:  res_ch.ready <= 1'($urandom_range(0, 1));
						RDY_PATTERN: res_ch.ready <= pat[k % 8];
						default:     res_ch.ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// Watchdog: a run that hangs ends here as a failure.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int                         ph;
		int                         n;
		int                         i;
		int                         pos;
		int                         phase_mark;
		int                         noise_cnt;
		int                         pick;
		logic [fmp_pkg::BYTE_W-1:0] len;
		logic [fmp_pkg::BYTE_W-1:0] b;
		logic [fmp_pkg::BYTE_W-1:0] rv;
		logic [fmp_pkg::BYTE_W-1:0] body[$];
		inject_t                    inj;

		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		arst_n        = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, registers at reset value: head and tail both zero.
		// A zero length byte rejects short and, though equal to head, is not hunted again;
		// the next zero starts a frame and a length of one rejects short as well.
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		wait_idle();

		// Extreme register values, then writes to indexes past the register file: if those
		// leaked into head or tail, the frames below would go wrong.
		set_regs(8'hFF, 8'h00);
		write_reg(REG_SPARE, 8'h00);
		write_reg(REG_TOP_IDX, 8'h80);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);

		// good frame, id equal to the head value and data with the top bit set
		body = {8'hFF, 8'h80};
		send_frame(8'd2, body, INJ_NONE);
		// tail value as the id byte: rejected with that byte as frame id
		body = {8'h00, 8'h11};
		send_frame(8'd2, body, INJ_TAIL_IN);
		// correct up to CR, then a wrong line feed
		body = {8'h01, 8'h02};
		send_frame(8'd2, body, INJ_LF);
		wait_idle();

		// Random part: mostly frames with random content, some broken on purpose, mixed
		// with noise bytes. New register values between phases, only while idle.
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			rv = 8'($urandom);
			case (ph)
				0:       set_regs(8'h00, 8'hFF);
				1:       set_regs(rv, rv);
				2:       set_regs(fmp_pkg::CHAR_CR, fmp_pkg::CHAR_LF);
				default: set_regs(8'($urandom), 8'($urandom));
			endcase
			// one long res stall while bytes keep coming
			if (ph == 1)
				hold_now = 1'b1;
			phase_mark = sent_total;
			noise_cnt  = 0;
			while (sent_total - phase_mark - noise_cnt < PER_PHASE) begin
				pick = $urandom_range(0, 3);
				if (pick == 0) begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						b = ($urandom_range(0, 3) == 0) ? head_cur : 8'($urandom);
						send_byte(b);
						noise_cnt++;
					end
				end else begin
					case ($urandom_range(0, 13))
						8:       inj = INJ_SHORT;
						9:       inj = INJ_TAIL_IN;
						10:      inj = INJ_NO_TAIL;
						11:      inj = INJ_SUM;
						12:      inj = INJ_CR;
						13:      inj = INJ_LF;
						default: inj = INJ_NONE;
					endcase
					// mostly short payloads, a few long ones up to the full byte range
					pick = $urandom_range(0, 99);
					if (pick < 2)
						len = 8'($urandom_range(128, 255));
					else if (pick < 5)
						len = 8'($urandom_range(13, 40));
					else
						len = 8'($urandom_range(2, 12));
					body.delete();
					if (inj == INJ_SHORT) begin
						len = 8'($urandom_range(0, 1));
					end else begin
						for (i = 0; i < len; i++) begin
							b = 8'($urandom);
							if (b == tail_cur)
								b = b ^ 8'h01;
							body.push_back(b);
						end
						if (inj == INJ_TAIL_IN) begin
							pos       = $urandom_range(0, len - 1);
							body[pos] = tail_cur;
						end
					end
					send_frame(len, body, inj);
				end
			end
		end

		// drain, then let anything stray come out
		wait_idle();
		repeat (6) @(negedge clk);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
